### rtl/multi_rate_ema_with_stdev_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-rate EMA block
// Clocked, reset-qualified assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef MULTI_RATE_EMA_WITH_STDEV_ASSERT_SVH
`define MULTI_RATE_EMA_WITH_STDEV_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define MREMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define MREMA_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/mrema_pkg.sv
// ----------------------------------------------------------------------------
// mrema_pkg
// Shared widths, codes and types of the multi-rate EMA block.
// ----------------------------------------------------------------------------
package mrema_pkg;

  localparam int SLOTS         = 3;
  localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FACTOR_INPUTS = 3;
  localparam int FIDX_W        = 2;

  localparam int SAMPLE_W = 24;
  localparam int FACTOR_W = 16;
  localparam int WEIGHT_W = FACTOR_W + 1;
  localparam int MEAN_W   = 40;
  localparam int MSQ_W    = 64;
  localparam int XSQ_W    = 2 * SAMPLE_W;
  localparam int STDEV_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FACTOR_W;
  localparam logic [CFG_W-1:0]    REPORT_SLOT_RST = CFG_W'(1);

  // shared multiplier operand and accumulator widths
  localparam int OPA_W  = 32;
  localparam int OPB_W  = 24;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 80;

  localparam int ROOT_ITER = 32;
  localparam int ITER_W    = $clog2(ROOT_ITER);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XSQ,
    ST_BLEND,
    ST_SQUARE,
    ST_SQWAIT,
    ST_VAR,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_32,
    SH_48
  } mac_sh_t;

  typedef enum logic [1:0] {
    DST_XSQ,
    DST_MEAN,
    DST_MSQ,
    DST_SQR
  } mac_dest_t;

  typedef struct packed {
    mac_dest_t          dest;
    logic [SLOT_W-1:0]  slot;
  } mac_tag_t;

  typedef struct packed {
    logic              valid;
    logic [OPA_W-1:0]  a;
    logic [OPB_W-1:0]  b;
    mac_sh_t           sh;
    logic              first;
    logic              last;
    mac_tag_t          tag;
  } mac_op_t;

  typedef struct packed {
    logic              valid;
    mac_tag_t          tag;
    logic [ACC_W-1:0]  acc;
  } mac_res_t;

endpackage

### rtl/mrema_req_if.sv
// ----------------------------------------------------------------------------
// mrema_req_if
// Input item channel: command, sample and per-slot retention factors.
// ----------------------------------------------------------------------------
interface mrema_req_if import mrema_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample;
  logic [FACTOR_W-1:0] factor_slot0;
  logic [FACTOR_W-1:0] factor_slot1;
  logic [FACTOR_W-1:0] factor_slot2;

  modport source (output valid, cmd, sample, factor_slot0, factor_slot1, factor_slot2,
                  input ready);
  modport sink   (input valid, cmd, sample, factor_slot0, factor_slot1, factor_slot2,
                  output ready);
endinterface

### rtl/mrema_rsp_if.sv
// ----------------------------------------------------------------------------
// mrema_rsp_if
// Result item channel: reported mean and standard deviation.
// ----------------------------------------------------------------------------
interface mrema_rsp_if import mrema_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_out;
  logic [STDEV_W-1:0] stdev_out;

  modport source (output valid, mean_out, stdev_out, input ready);
  modport sink   (input valid, mean_out, stdev_out, output ready);
endinterface

### rtl/mrema_mac.sv
// ----------------------------------------------------------------------------
// mrema_mac
// Shared 32x24 multiplier with a registered product and an 80-bit
// shift-accumulate stage; one partial product per cycle.
// ----------------------------------------------------------------------------
module mrema_mac import mrema_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mac_op_t  op,
  output mac_res_t res
);

  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  mac_sh_t           prod_sh;
  logic              prod_first;
  logic              prod_last;
  mac_tag_t          prod_tag;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      prod       <= {{OPB_W{1'b0}}, op.a} * {{OPA_W{1'b0}}, op.b};
      prod_sh    <= op.sh;
      prod_first <= op.first;
      prod_last  <= op.last;
      prod_tag   <= op.tag;
    end
  end

  always_comb begin
    unique case (prod_sh)
      SH_0:    addend = ACC_W'(prod);
      SH_24:   addend = ACC_W'(prod) << 24;
      SH_32:   addend = ACC_W'(prod) << 32;
      SH_48:   addend = ACC_W'(prod) << 48;
      default: addend = ACC_W'(prod);
    endcase
    // first term of a group restarts the sum
    sum = (prod_first ? '0 : acc) + addend;
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= sum;
    end
  end

  assign res.valid = prod_valid && prod_last;
  assign res.tag   = prod_tag;
  assign res.acc   = sum;

endmodule

### rtl/mrema_isqrt.sv
// ----------------------------------------------------------------------------
// mrema_isqrt
// Bit-pair restoring integer square root of a 64-bit value, one result
// bit per cycle.
// ----------------------------------------------------------------------------
module mrema_isqrt import mrema_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MSQ_W-1:0]   value,
  output logic               done,
  output logic [STDEV_W-1:0] root
);

  logic              busy;
  logic [ITER_W-1:0] cnt;
  logic [MSQ_W-1:0]  rem;
  logic [MSQ_W-1:0]  res;
  logic [MSQ_W-1:0]  bit_r;
  logic [MSQ_W-1:0]  trial;

  assign trial = res + bit_r;
  assign done  = busy && (cnt == ITER_W'(ROOT_ITER - 1));
  assign root  = res[STDEV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + ITER_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= value;
      res   <= '0;
      bit_r <= MSQ_W'(1) << (MSQ_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

### rtl/multi_rate_ema_with_stdev.sv
// ----------------------------------------------------------------------------
// multi_rate_ema_with_stdev
// Multi-rate exponential moving average with standard deviation.
// ----------------------------------------------------------------------------
// req.ready is high only while idle, so a new item is accepted only once
// the previous one has gone through every step and its result has been
// loaded into the output register.
// The one shared 32x24 multiply-accumulate unit does one partial product
// per cycle (one for the sample square, eight per slot for the mean and
// mean-square blends, four for the squared mean), and the square root
// unit produces one result bit per cycle.
// A set command (cmd=1) runs the same blend with factor zero, so it
// takes as long as a blend. The result sits in an output register: a new
// item is accepted while the previous result waits to be taken, and the
// block only stalls at the end of an item if that register is still full.
// report_slot may be written whenever the block is idle.
// ----------------------------------------------------------------------------
`include "multi_rate_ema_with_stdev_assert.svh"

module multi_rate_ema_with_stdev import mrema_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  mrema_req_if.sink        req,
  mrema_rsp_if.source      rsp
);

  state_t state, state_next;

  logic [CFG_W-1:0]    report_slot;
  logic                cmd_r;
  logic [SAMPLE_W-1:0] x_r;
  logic [FACTOR_W-1:0] factor_r [FACTOR_INPUTS];
  logic [XSQ_W-1:0]    xsq;
  logic [MSQ_W-1:0]    sq_r;
  logic [MEAN_W-1:0]   mean_res;

  logic [MEAN_W-1:0]   slot_mean        [SLOTS];
  logic [MSQ_W-1:0]    slot_mean_square [SLOTS];

  logic [SLOT_W-1:0]   slot_idx, slot_idx_next;
  logic                qsel, qsel_next;
  logic [1:0]          term, term_next;

  logic [SLOT_W-1:0]   rs_idx;
  logic [SLOT_W-1:0]   rd_idx;
  logic [MEAN_W-1:0]   mean_rd;
  logic [MSQ_W-1:0]    msq_rd;
  logic [FIDX_W-1:0]   fidx;
  logic [WEIGHT_W-1:0] k_eff;
  logic [WEIGHT_W-1:0] kk;
  logic [MSQ_W-1:0]    blend_a;
  logic [MSQ_W-1:0]    blend_b;
  logic [MSQ_W-1:0]    variance;

  mac_op_t             mac_op;
  mac_res_t            mac_res;

  logic                root_start;
  logic                root_done;
  logic [STDEV_W-1:0]  root;
  logic                load_out;

  mrema_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .res (mac_res)
  );

  mrema_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (variance),
    .done  (root_done),
    .root  (root)
  );

  // out-of-range report slot falls back to the last slot
  assign rs_idx = (32'(report_slot) >= SLOTS) ? SLOT_W'(SLOTS - 1) : SLOT_W'(report_slot);
  assign rd_idx = (state == ST_BLEND) ? slot_idx : rs_idx;
  assign mean_rd = slot_mean[rd_idx];
  assign msq_rd  = slot_mean_square[rd_idx];

  // slots past the last factor input share it
  assign fidx  = (32'(slot_idx) >= FACTOR_INPUTS - 1) ? FIDX_W'(FACTOR_INPUTS - 1)
                                                      : FIDX_W'(slot_idx);
  // set command is a blend with k = 0, which yields the sample exactly
  assign k_eff = cmd_r ? '0 : {1'b0, factor_r[fidx]};
  assign kk    = WEIGHT_ONE - k_eff;

  assign blend_a = qsel ? msq_rd : MSQ_W'(mean_rd);
  assign blend_b = qsel ? {xsq, {FRAC_W{1'b0}}} : MSQ_W'({x_r, {FRAC_W{1'b0}}});

  assign variance = (msq_rd > sq_r) ? (msq_rd - sq_r) : '0;

  assign req.ready  = (state == ST_IDLE);
  assign root_start = (state == ST_VAR);
  assign load_out   = (state == ST_OUT) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next    = state;
    slot_idx_next = slot_idx;
    qsel_next     = qsel;
    term_next     = term;
    mac_op        = '0;
    mac_op.sh     = SH_0;
    mac_op.tag.dest = DST_XSQ;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next    = ST_XSQ;
          slot_idx_next = '0;
          qsel_next     = 1'b0;
          term_next     = '0;
        end
      end
      ST_XSQ: begin
        mac_op.valid    = 1'b1;
        mac_op.a        = OPA_W'(x_r);
        mac_op.b        = OPB_W'(x_r);
        mac_op.first    = 1'b1;
        mac_op.last     = 1'b1;
        mac_op.tag.dest = DST_XSQ;
        state_next      = ST_BLEND;
      end
      ST_BLEND: begin
        mac_op.valid    = 1'b1;
        mac_op.first    = (term == 2'd0);
        mac_op.last     = (term == 2'd3);
        mac_op.tag.dest = qsel ? DST_MSQ : DST_MEAN;
        mac_op.tag.slot = slot_idx;
        unique case (term)
          2'd0: begin
            mac_op.a  = blend_a[OPA_W-1:0];
            mac_op.b  = OPB_W'(k_eff);
            mac_op.sh = SH_0;
          end
          2'd1: begin
            mac_op.a  = blend_b[OPA_W-1:0];
            mac_op.b  = OPB_W'(kk);
            mac_op.sh = SH_0;
          end
          2'd2: begin
            mac_op.a  = blend_a[MSQ_W-1:OPA_W];
            mac_op.b  = OPB_W'(k_eff);
            mac_op.sh = SH_32;
          end
          default: begin
            mac_op.a  = blend_b[MSQ_W-1:OPA_W];
            mac_op.b  = OPB_W'(kk);
            mac_op.sh = SH_32;
          end
        endcase
        term_next = term + 2'd1;
        if (term == 2'd3) begin
          qsel_next = ~qsel;
          if (qsel) begin
            if (slot_idx == SLOT_W'(SLOTS - 1)) begin
              slot_idx_next = '0;
              state_next    = ST_SQUARE;
            end else begin
              slot_idx_next = slot_idx + SLOT_W'(1);
            end
          end
        end
      end
      ST_SQUARE: begin
        // mean^2 from a 16-bit high and a 24-bit low part
        mac_op.valid    = 1'b1;
        mac_op.first    = (term == 2'd0);
        mac_op.last     = (term == 2'd3);
        mac_op.tag.dest = DST_SQR;
        mac_op.tag.slot = rs_idx;
        unique case (term)
          2'd0: begin
            mac_op.a  = OPA_W'(mean_rd[OPB_W-1:0]);
            mac_op.b  = mean_rd[OPB_W-1:0];
            mac_op.sh = SH_0;
          end
          2'd1, 2'd2: begin
            mac_op.a  = OPA_W'(mean_rd[MEAN_W-1:OPB_W]);
            mac_op.b  = mean_rd[OPB_W-1:0];
            mac_op.sh = SH_24;
          end
          default: begin
            mac_op.a  = OPA_W'(mean_rd[MEAN_W-1:OPB_W]);
            mac_op.b  = OPB_W'(mean_rd[MEAN_W-1:OPB_W]);
            mac_op.sh = SH_48;
          end
        endcase
        term_next = term + 2'd1;
        if (term == 2'd3) begin
          state_next = ST_SQWAIT;
        end
      end
      ST_SQWAIT: begin
        state_next = ST_VAR;
      end
      ST_VAR: begin
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (root_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot_idx <= '0;
      qsel     <= 1'b0;
      term     <= '0;
    end else begin
      state    <= state_next;
      slot_idx <= slot_idx_next;
      qsel     <= qsel_next;
      term     <= term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_slot <= REPORT_SLOT_RST;
    end else if (cfg_we) begin
      report_slot <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r       <= req.cmd;
      x_r         <= req.sample;
      factor_r[0] <= req.factor_slot0;
      factor_r[1] <= req.factor_slot1;
      factor_r[2] <= req.factor_slot2;
    end
    if (state == ST_VAR) begin
      mean_res <= mean_rd;
    end
    if (mac_res.valid) begin
      unique case (mac_res.tag.dest)
        DST_XSQ: xsq  <= mac_res.acc[XSQ_W-1:0];
        DST_SQR: sq_r <= mac_res.acc[ACC_W-1:FRAC_W];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_mean[i]        <= '0;
        slot_mean_square[i] <= '0;
      end
    end else if (mac_res.valid) begin
      if (mac_res.tag.dest == DST_MEAN) begin
        slot_mean[mac_res.tag.slot] <= mac_res.acc[MEAN_W+FRAC_W-1:FRAC_W];
      end
      if (mac_res.tag.dest == DST_MSQ) begin
        slot_mean_square[mac_res.tag.slot] <= mac_res.acc[ACC_W-1:FRAC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.mean_out  <= mean_res;
      rsp.stdev_out <= root;
    end
  end

  `MREMA_ASSERT(a_sqr_timing, clk, rst,
    (mac_res.valid && mac_res.tag.dest == DST_SQR) |-> (state == ST_SQWAIT), "squared mean late")
  `MREMA_ASSERT_NEVER(a_idle_quiet, clk, rst,
    (state == ST_IDLE) && mac_res.valid, "accumulator result while idle")
  `MREMA_ASSERT(a_out_source, clk, rst,
    $rose(rsp.valid) |-> $past(state == ST_OUT), "result appeared outside output step")
  `MREMA_ASSERT(a_root_in_sqrt, clk, rst,
    root_done |-> (state == ST_SQRT), "square root finished outside its step")

endmodule
